### design/cobsdf_pkg.sv
// shared types, constants and checksum function of the cobs deframer
package cobsdf_pkg;

   localparam int unsigned MaxFrameCount = 511;
   localparam int unsigned LenWidth      = $clog2(MaxFrameCount + 1);
   localparam int unsigned CsrAddrWidth  = 3;
   localparam int unsigned CsrDataWidth  = 32;

   localparam logic [7:0]  DelimiterByte = 8'h00;
   localparam logic [7:0]  MaxCodeByte   = 8'hFF;
   localparam logic [15:0] CrcInit       = 16'hFFFF;
   localparam logic [15:0] CrcPolyRefl   = 16'h8408;
   localparam logic [15:0] CrcXorOut     = 16'hFFFF;
   localparam logic [7:0]  MinLenReset   = 8'd4;

   // register index, taken from the word address bit
   localparam logic [0:0] CSR_MIN_FRAME_LENGTH = 1'b0;

   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_GOOD      = 2'd0,
      STATUS_BAD_CRC   = 2'd1,
      STATUS_TOO_SHORT = 2'd2
   } status_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      status_type frame_status;
   } rsp_type;

   // one byte of reflected crc-16/x-25, lsb first
   function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CrcPolyRefl) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### design/cobsdf_core.sv
// cobs decode, two-byte holdback, crc and end-of-frame status
module cobsdf_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           in_byte,
   input  logic [7:0]           min_len,
   output logic                 push,
   output cobsdf_pkg::rsp_type  result
);
   import cobsdf_pkg::*;

   logic [7:0]          group_ff, group_in;
   logic                short_ff, short_in;
   logic [LenWidth-1:0] len_ff, len_in;
   logic [7:0]          hb0_ff, hb0_in;
   logic [7:0]          hb1_ff, hb1_in;
   logic [1:0]          fill_ff, fill_in;
   logic [15:0]         crc_ff, crc_in;

   logic       dec_valid;
   logic [7:0] dec_byte;
   logic [15:0] rx_crc;

   assign rx_crc = {hb1_ff, hb0_ff};

   always_comb begin
      group_in  = group_ff;
      short_in  = short_ff;
      len_in    = len_ff;
      hb0_in    = hb0_ff;
      hb1_in    = hb1_ff;
      fill_in   = fill_ff;
      crc_in    = crc_ff;
      dec_valid = 1'b0;
      dec_byte  = 8'h00;
      push      = 1'b0;
      result    = '{kind: KIND_DATA, data_byte: 8'h00, frame_status: STATUS_GOOD};

      if (step && in_byte == DelimiterByte) begin
         push        = 1'b1;
         result.kind = KIND_STATUS;
         if (len_ff < {{(LenWidth-8){1'b0}}, min_len}) begin
            result.frame_status = STATUS_TOO_SHORT;
         end else if (fill_ff < 2'd2) begin
            result.frame_status = STATUS_BAD_CRC;
         end else if (rx_crc == (crc_ff ^ CrcXorOut)) begin
            result.frame_status = STATUS_GOOD;
         end else begin
            result.frame_status = STATUS_BAD_CRC;
         end
         group_in = 8'h00;
         short_in = 1'b0;
         len_in   = '0;
         fill_in  = 2'd0;
         crc_in   = CrcInit;
      end else if (step) begin
         if (len_ff < LenWidth'(MaxFrameCount)) begin
            len_in = len_ff + 1'b1;
         end
         if (group_ff == 8'h00) begin
            // code byte: a short previous group ends in an implied zero
            dec_valid = short_ff;
            dec_byte  = 8'h00;
            short_in  = (in_byte != MaxCodeByte);
            group_in  = in_byte - 8'd1;
         end else begin
            dec_valid = 1'b1;
            dec_byte  = in_byte;
            group_in  = group_ff - 8'd1;
         end
         if (dec_valid) begin
            if (fill_ff < 2'd2) begin
               if (fill_ff[0]) hb1_in = dec_byte;
               else            hb0_in = dec_byte;
               fill_in = fill_ff + 2'd1;
            end else begin
               push             = 1'b1;
               result.data_byte = hb0_ff;
               crc_in           = crc_byte(crc_ff, hb0_ff);
               hb0_in           = hb1_ff;
               hb1_in           = dec_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff <= 8'h00;
         short_ff <= 1'b0;
         len_ff   <= '0;
         fill_ff  <= 2'd0;
         crc_ff   <= CrcInit;
      end else begin
         group_ff <= group_in;
         short_ff <= short_in;
         len_ff   <= len_in;
         fill_ff  <= fill_in;
         crc_ff   <= crc_in;
      end
      hb0_ff <= hb0_in;
      hb1_ff <= hb1_in;
   end

   holdback_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 2'd2)
      else $error("holdback fill above two");

   data_needs_full_holdback: assert property (@(posedge clock) disable iff (reset)
      push && result.kind == KIND_DATA |-> fill_ff == 2'd2)
      else $error("byte released before holdback is full");

   length_saturates: assert property (@(posedge clock) disable iff (reset)
      step && in_byte != DelimiterByte |=> len_ff != '0)
      else $error("length counter wrapped");

endmodule

### design/cobsdf_out_fifo.sv
// two-entry result buffer that decouples the core from the result channel
module cobsdf_out_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cobsdf_pkg::rsp_type push_data,
   output logic                room,
   output logic                out_valid,
   input  logic                out_ready,
   output cobsdf_pkg::rsp_type out_data
);
   import cobsdf_pkg::*;

   rsp_type    mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign room      = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> room)
      else $error("push into full result buffer");

   count_in_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result buffer count out of range");

   pointers_track_count: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) == (wr_ff != rd_ff))
      else $error("result buffer pointers disagree with count");

endmodule

### design/cobs_deframer_crc16_check.sv
// top level of the cobs deframer with crc-16/x-25 frame check
//
// takes one raw link byte per req transaction; a 0x00 byte closes a frame.
// bytes between delimiters are cobs-decoded, and decoded bytes leave on rsp
// two bytes late, since the last two decoded bytes of a frame are its crc
// (low byte first) and are never forwarded. each delimiter yields one status
// transaction (tuser high): good, crc mismatch, or too short when fewer than
// min_frame_length encoded bytes came in. throughput is one byte per clock
// while the result buffer has room; a byte reaches rsp through two register
// stages (input register, then the decode/crc logic writes the two-entry
// result buffer). when the result buffer is full the input register holds its
// byte and req_tready drops. the byte-wide crc update and the group counter
// sit in one stage, which sets the clock rate. min_frame_length sits at csr
// address 0 and should only be written while no frame traffic is in flight.
module cobs_deframer_crc16_check (
   input  logic                                      clock,
   input  logic                                      reset,
   // input stream
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [7:0]                                req_tdata,    // [7:0] in_byte
   // result stream
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [15:0]                               rsp_tdata,    // [7:0] data_byte,
                                                                   // [9:8] frame_status
   output logic                                      rsp_tuser,    // [0] result_kind
   // register port
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [cobsdf_pkg::CsrAddrWidth-1:0]       csr_paddr,
   input  logic [cobsdf_pkg::CsrDataWidth-1:0]       csr_pwdata,
   output logic [cobsdf_pkg::CsrDataWidth-1:0]       csr_prdata,
   output logic                                      csr_pready
);
   import cobsdf_pkg::*;

   // min frame length register
   logic [7:0] min_len_ff;
   logic       csr_wr;
   logic       csr_hit;

   // input register stage
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       advance;

   // core to buffer
   logic    push;
   rsp_type core_rsp;
   logic    room;
   rsp_type out_rsp;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CsrAddrWidth-1] == CSR_MIN_FRAME_LENGTH) &&
                       (csr_paddr[CsrAddrWidth-2:0] == '0);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? {{(CsrDataWidth-8){1'b0}}, min_len_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= MinLenReset;
      end else if (csr_wr && csr_hit) begin
         min_len_ff <= csr_pwdata[7:0];
      end
   end

   // the held byte is processed whenever the buffer has a free slot
   assign advance    = in_valid_ff && room;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   cobsdf_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (in_byte_ff),
      .min_len (min_len_ff),
      .push    (push),
      .result  (core_rsp)
   );

   cobsdf_out_fifo u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (core_rsp),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_rsp)
   );

   // unused fields are zero in both kinds of result
   assign rsp_tdata = {6'b000000, out_rsp.frame_status, out_rsp.data_byte};
   assign rsp_tuser = out_rsp.kind;

   status_only_on_delimiter: assert property (@(posedge clock) disable iff (reset)
      push && core_rsp.kind == KIND_STATUS |-> in_byte_ff == DelimiterByte)
      else $error("status result without delimiter");

   data_result_clean: assert property (@(posedge clock) disable iff (reset)
      push && core_rsp.kind == KIND_DATA |-> core_rsp.frame_status == STATUS_GOOD)
      else $error("data result carries a status");

   delimiter_always_reports: assert property (@(posedge clock) disable iff (reset)
      advance && in_byte_ff == DelimiterByte |-> push)
      else $error("delimiter gave no status");

   held_byte_waits: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !room |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held byte lost while buffer full");

endmodule

### tb/testbench.sv
// self-checking testbench for the cobs deframer with crc-16/x-25 frame check
module testbench;
   import cobsdf_pkg::*;

   // run limit in clock cycles, far above the slowest legal run
   localparam int unsigned CycleLimit  = 400000;
   // quiet cycles after the last result, covers the pipeline
   localparam int unsigned DrainCycles = 8;
   // byte address of the minimum frame length register
   localparam logic [CsrAddrWidth-1:0] MinLenAddr = {CSR_MIN_FRAME_LENGTH, 2'b00};

   typedef logic [7:0] octet_q [$];

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [7:0]              req_tdata;     // [7:0] in_byte
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [15:0]             rsp_tdata;     // [7:0] data_byte, [9:8] frame_status
   logic                    rsp_tuser;     // [0] result_kind
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [CsrDataWidth-1:0] csr_pwdata;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   cobs_deframer_crc16_check dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // idle rates in percent, changed between phases
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned items_sent     = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;

   // results predicted but not yet seen on rsp
   rsp_type pending_results[$];

   // deframer shadow state
   logic [7:0]          min_len_setting;
   logic [7:0]          group_left;
   bit                  last_code_short;
   logic [LenWidth-1:0] frame_len;
   logic [7:0]          held_bytes [2];
   int unsigned         held_count;
   logic [15:0]         running_crc;

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // reflected crc-16/x-25 over one byte, lsb first
   function automatic logic [15:0] x25_crc_update(logic [15:0] acc, logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      repeat (8) begin
         if (c[0]) c = (c >> 1) ^ CrcPolyRefl;
         else      c = c >> 1;
      end
      return c;
   endfunction

   function automatic void clear_frame_state();
      group_left      = 8'h00;
      last_code_short = 1'b0;
      frame_len       = '0;
      held_bytes[0]   = 8'h00;
      held_bytes[1]   = 8'h00;
      held_count      = 0;
      running_crc     = CrcInit;
   endfunction

   // two-byte holdback: a byte only leaves (and enters the crc) once two
   // newer decoded bytes exist, so the trailing crc is never forwarded
   function automatic bit shift_decoded(logic [7:0] b, output logic [7:0] leaving);
      leaving = 8'h00;
      if (held_count < 2) begin
         held_bytes[held_count] = b;
         held_count++;
         return 1'b0;
      end
      leaving       = held_bytes[0];
      running_crc   = x25_crc_update(running_crc, held_bytes[0]);
      held_bytes[0] = held_bytes[1];
      held_bytes[1] = b;
      return 1'b1;
   endfunction

   // expected results of one accepted link byte
   function automatic void decode_link_byte(logic [7:0] b);
      rsp_type     r;
      logic [7:0]  leaving;
      bit          emitted;
      logic [15:0] rx_crc;
      leaving = 8'h00;
      emitted = 1'b0;
      if (b == DelimiterByte) begin
         r.kind      = KIND_STATUS;
         r.data_byte = 8'h00;
         // too short wins over the checksum, then a missing checksum is bad
         if (frame_len < {1'b0, min_len_setting}) begin
            r.frame_status = STATUS_TOO_SHORT;
         end else if (held_count < 2) begin
            r.frame_status = STATUS_BAD_CRC;
         end else begin
            rx_crc = {held_bytes[1], held_bytes[0]};
            r.frame_status = (rx_crc == (running_crc ^ CrcXorOut)) ? STATUS_GOOD
                                                                   : STATUS_BAD_CRC;
         end
         pending_results.push_back(r);
         clear_frame_state();
         return;
      end
      // encoded length saturates instead of wrapping
      if (frame_len < MaxFrameCount) frame_len++;
      if (group_left == 8'h00) begin
         // code byte: a short group before it implies a zero
         if (last_code_short) emitted = shift_decoded(8'h00, leaving);
         last_code_short = (b < MaxCodeByte);
         group_left      = b - 8'd1;
      end else begin
         emitted    = shift_decoded(b, leaving);
         group_left = group_left - 8'd1;
      end
      if (emitted) begin
         r.kind         = KIND_DATA;
         r.data_byte    = leaving;
         r.frame_status = STATUS_GOOD;
         pending_results.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------------
   // frame building
   // ---------------------------------------------------------------------

   // append the x-25 checksum (low byte first) and cobs-encode, no delimiter
   function automatic octet_q encode_checked_frame(octet_q payload);
      octet_q      body;
      octet_q      link;
      logic [15:0] crc;
      int          code_at;
      logic [7:0]  code;
      body = payload;
      crc  = CrcInit;
      foreach (payload[i]) crc = x25_crc_update(crc, payload[i]);
      crc = crc ^ CrcXorOut;
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);
      code_at = 0;
      code    = 8'd1;
      link.push_back(8'h00);
      foreach (body[i]) begin
         if (body[i] == 8'h00) begin
            link[code_at] = code;
            code_at       = link.size();
            link.push_back(8'h00);
            code          = 8'd1;
         end else begin
            link.push_back(body[i]);
            code = code + 8'd1;
            // full group of 254 literals, next code implies no zero
            if (code == MaxCodeByte) begin
               link[code_at] = code;
               code_at       = link.size();
               link.push_back(8'h00);
               code          = 8'd1;
            end
         end
      end
      link[code_at] = code;
      return link;
   endfunction

   // payload bytes lean toward zero so that short groups are common
   function automatic logic [7:0] random_payload_byte();
      if ($urandom_range(3) == 0) return 8'h00;
      return 8'($urandom_range(1, 255));
   endfunction

   // ---------------------------------------------------------------------
   // stimulus side
   // ---------------------------------------------------------------------

   // one req transaction; called and left at a falling edge with valid high
   task automatic send_link_byte(input logic [7:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      decode_link_byte(b);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input octet_q link);
      foreach (link[i]) send_link_byte(link[i]);
      send_link_byte(DelimiterByte);
   endtask

   // stop sending and wait for every predicted result, plus pipeline slack
   task automatic drain_link();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      @(negedge clock);
   endtask

   // write the register, then read it back; only while the link is drained
   task automatic set_min_frame_length(input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MinLenAddr;
      csr_pwdata  <= {{(CsrDataWidth - 8){1'b0}}, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      min_len_setting = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[7:0] !== value) begin
         mismatch_count++;
         $display("%0t min_frame_length readback expected %0d actual %0d",
                  $time, value, csr_prdata[7:0]);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------------

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // every rsp transaction against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t unexpected result expected none actual kind %0d tdata %h",
                     $time, rsp_tuser, rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.kind) begin
               mismatch_count++;
               $display("%0t result_kind expected %0d actual %0d",
                        $time, want.kind, rsp_tuser);
            end
            if (rsp_tdata[7:0] !== want.data_byte) begin
               mismatch_count++;
               $display("%0t data_byte expected %h actual %h",
                        $time, want.data_byte, rsp_tdata[7:0]);
            end
            if (rsp_tdata[9:8] !== want.frame_status) begin
               mismatch_count++;
               $display("%0t frame_status expected %0d actual %0d",
                        $time, want.frame_status, rsp_tdata[9:8]);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset minimum of 4: empty frame, good frame, checksum mismatch
   task automatic test_frame_outcomes();
      octet_q link;
      send_link_byte(DelimiterByte);
      // extreme payload values, zero needs insertion by a later code byte
      link = encode_checked_frame('{8'h00, 8'hFF});
      send_frame(link);
      link[link.size() - 1] = link[link.size() - 1] ^ 8'h80;
      send_frame(link);
      drain_link();
   endtask

   // minimum lengths at both extremes and the degenerate frame shapes
   task automatic test_short_frames();
      set_min_frame_length(8'd0);
      // empty frame passes the length check but has no checksum
      send_link_byte(DelimiterByte);
      // only one decoded byte
      send_frame('{8'h02, 8'h41});
      // delimiter inside a group ends the frame with no zero added
      send_frame('{8'h05, 8'h12, 8'h34});
      drain_link();
      set_min_frame_length(8'd255);
      // correct checksum but far below the minimum
      send_frame(encode_checked_frame('{8'h5A}));
      drain_link();
   endtask

   // more than 511 encoded bytes with full 0xff groups; a wrapping length
   // counter would fall below the minimum and report too short
   task automatic test_saturated_length();
      octet_q payload;
      set_min_frame_length(8'd255);
      repeat (254) payload.push_back(8'($urandom_range(1, 255)));
      payload.push_back(8'h00);
      repeat (260) payload.push_back(random_payload_byte());
      send_frame(encode_checked_frame(payload));
      drain_link();
   endtask

   // mostly well-formed frames, plus damaged frames and raw noise
   task automatic test_random_traffic(input int unsigned byte_budget);
      int unsigned stop_at;
      int unsigned sel;
      int unsigned n;
      int unsigned idx;
      octet_q      payload;
      octet_q      link;
      stop_at = items_sent + byte_budget;
      while (items_sent < stop_at) begin
         payload = {};
         link    = {};
         sel     = $urandom_range(99);
         n = ($urandom_range(9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
         repeat (n) payload.push_back(random_payload_byte());
         if (sel < 85) begin
            link = encode_checked_frame(payload);
            if (sel >= 70) begin
               idx = $urandom_range(0, link.size() - 1);
               case ($urandom_range(2))
                  0: begin
                     // single bit error, a zero result truncates the frame
                     link[idx] = link[idx] ^ (8'h01 << $urandom_range(0, 7));
                  end
                  1: begin
                     link.delete(idx);
                  end
                  default: begin
                     while (link.size() > idx) void'(link.pop_back());
                  end
               endcase
            end
         end else begin
            // noise, may hold delimiters of its own
            repeat ($urandom_range(0, 12)) link.push_back(8'($urandom_range(0, 255)));
         end
         send_frame(link);
         // now and then let the result stream run dry before going on
         if ($urandom_range(99) < 4) drain_link();
      end
      drain_link();
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      min_len_setting = MinLenReset;
      clear_frame_state();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sender idles a little, receiver stalls a lot
      send_idle_pct  = 29;
      recv_stall_pct = 80;
      test_frame_outcomes();
      test_short_frames();
      set_min_frame_length(8'($urandom_range(1, 12)));
      test_random_traffic(285);

      // sender idles a lot, receiver stalls a little
      send_idle_pct  = 80;
      recv_stall_pct = 29;
      test_saturated_length();
      set_min_frame_length(8'd0);
      test_random_traffic(285);

      // back to back in both directions
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      set_min_frame_length(8'($urandom_range(0, 20)));
      test_random_traffic(285);

      drain_link();
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
